// File: rtl/core/odu_channel_change_sender_core_defines.svh
// Assertion macros shared by the channel change sender modules.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ODU_CHANNEL_CHANGE_SENDER_CORE_DEFINES_SVH
`define ODU_CHANNEL_CHANGE_SENDER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ODU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ODU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/odu_ccs_pkg.sv
// Package for the channel change sender: payload structs, register set,
// register index codes and reset values. No dependencies.
`default_nettype none

package odu_ccs_pkg;

	// Register index codes on the configuration port.
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 14;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_US        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_US         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND_EDGE_MHZ   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_LO_MHZ      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LO_MHZ     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TUNE_OFFSET_MHZ = 3'd5;

	// Register reset values.
	localparam logic [10:0] RST_SHORT_US        = 11'd500;
	localparam logic [10:0] RST_LONG_US         = 11'd1000;
	localparam logic [13:0] RST_BAND_EDGE_MHZ   = 14'd11700;
	localparam logic [13:0] RST_LOW_LO_MHZ      = 14'd9750;
	localparam logic [13:0] RST_HIGH_LO_MHZ     = 14'd10600;
	localparam logic [9:0]  RST_TUNE_OFFSET_MHZ = 10'd100;

	// Command word prefix in the top byte and word length in bits.
	localparam logic [7:0] CMD_PREFIX = 8'h70;
	localparam logic [5:0] WORD_BITS  = 6'd32;

	// Request codes.
	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_START = 1'b1;

	typedef struct packed {
		logic [10:0] short_us;
		logic [10:0] long_us;
		logic [13:0] band_edge_mhz;
		logic [13:0] low_lo_mhz;
		logic [13:0] high_lo_mhz;
		logic [9:0]  tune_offset_mhz;
	} cfg_t;

	typedef struct packed {
		logic        req_type;
		logic [5:0]  channel;
		logic [13:0] freq_mhz;
		logic        polarity;
	} in_item_t;

	typedef struct packed {
		logic        tone_on;
		logic        busy_res;
		logic        frame_done;
		logic        start_ignored;
		logic [31:0] command_word;
	} out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/odu_ccs_cfg.sv
// Configuration register file of the channel change sender.
// Depends on odu_ccs_pkg for the register struct, index codes and resets.
`default_nettype none

module odu_ccs_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [odu_ccs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [odu_ccs_pkg::CFG_DATA_W-1:0] cfg_data,
	output odu_ccs_pkg::cfg_t                       cfg
);
	import odu_ccs_pkg::*;

	cfg_t cfg_q;

	// Write one register per enabled cycle; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_us        <= RST_SHORT_US;
			cfg_q.long_us         <= RST_LONG_US;
			cfg_q.band_edge_mhz   <= RST_BAND_EDGE_MHZ;
			cfg_q.low_lo_mhz      <= RST_LOW_LO_MHZ;
			cfg_q.high_lo_mhz     <= RST_HIGH_LO_MHZ;
			cfg_q.tune_offset_mhz <= RST_TUNE_OFFSET_MHZ;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SHORT_US:        cfg_q.short_us        <= cfg_data[10:0];
				CFG_LONG_US:         cfg_q.long_us         <= cfg_data[10:0];
				CFG_BAND_EDGE_MHZ:   cfg_q.band_edge_mhz   <= cfg_data;
				CFG_LOW_LO_MHZ:      cfg_q.low_lo_mhz      <= cfg_data;
				CFG_HIGH_LO_MHZ:     cfg_q.high_lo_mhz     <= cfg_data;
				CFG_TUNE_OFFSET_MHZ: cfg_q.tune_offset_mhz <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/core/odu_ccs_word.sv
// Command word assembly: band choice, tune value and polarity code.
// Depends on odu_ccs_pkg for the register struct and the word prefix.
`default_nettype none

module odu_ccs_word (
	input  wire odu_ccs_pkg::cfg_t cfg,
	input  wire logic [5:0]    channel,
	input  wire logic [13:0]   freq_mhz,
	input  wire logic          polarity,
	output logic [31:0]        word
);
	import odu_ccs_pkg::*;

	logic        low_band;
	logic [13:0] lo_mhz;
	logic [31:0] tune;
	logic [7:0]  ch;
	logic [1:0]  pol_base;
	logic [1:0]  pol;

	// Pick the band oscillator and form the tune value with 32-bit wrap.
	always_comb begin
		low_band = (freq_mhz <= cfg.band_edge_mhz);
		lo_mhz   = low_band ? cfg.low_lo_mhz : cfg.high_lo_mhz;
		tune     = {18'd0, freq_mhz} - {18'd0, lo_mhz} - {22'd0, cfg.tune_offset_mhz};
		ch       = {2'd0, channel} - 8'd1;
		pol_base = polarity ? 2'd3 : 2'd1;
		pol      = low_band ? (pol_base - 2'd1) : pol_base;
		word     = {CMD_PREFIX, 24'd0} + {5'd0, ch, 19'd0} + {tune[23:0], 8'd0}
			+ {30'd0, pol};
	end

endmodule

`default_nettype wire

// File: rtl/core/odu_ccs_seq.sv
// Bit sequencer: holds the word being sent and the segment timer, and forms
// one result per accepted item. Depends on odu_ccs_pkg and odu_ccs_word.
`default_nettype none
`include "odu_channel_change_sender_core_defines.svh"

module odu_ccs_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire odu_ccs_pkg::cfg_t cfg,
	input  wire logic              accept,
	input  wire odu_ccs_pkg::in_item_t item,
	output odu_ccs_pkg::out_item_t res
);
	import odu_ccs_pkg::*;

	logic [31:0] shift_word_q;
	logic [5:0]  bits_left_q;
	logic        in_silence_q;
	logic [10:0] tick_count_q;
	logic        sending_q;

	logic [31:0] word;
	logic        is_start;
	logic        use_long;
	logic [10:0] seg_len;
	logic        seg_end;
	logic        last_bit;

	odu_ccs_word u_word (
		.cfg      (cfg),
		.channel  (item.channel),
		.freq_mhz (item.freq_mhz),
		.polarity (item.polarity),
		.word     (word)
	);

	// Segment length: a one is short tone then long silence, a zero the reverse.
	always_comb begin
		is_start = (item.req_type == REQ_START);
		use_long = (in_silence_q == shift_word_q[31]);
		seg_len  = use_long ? cfg.long_us : cfg.short_us;
		seg_end  = ({1'b0, tick_count_q} + 12'd1) >= {1'b0, seg_len};
		last_bit = (bits_left_q == 6'd1);
	end

	// Result of the current item, from the state before it is applied.
	always_comb begin
		res = '0;
		if (is_start) begin
			res.busy_res = 1'b1;
			if (sending_q) begin
				res.start_ignored = 1'b1;
			end else begin
				res.command_word = word;
			end
		end else if (sending_q) begin
			res.tone_on    = !in_silence_q;
			res.busy_res   = 1'b1;
			res.frame_done = seg_end && in_silence_q && last_bit;
		end
	end

	// Control state advances only on accepted transfers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_left_q  <= '0;
			in_silence_q <= 1'b0;
			tick_count_q <= '0;
			sending_q    <= 1'b0;
		end else if (accept) begin
			if (is_start) begin
				if (!sending_q) begin
					bits_left_q  <= WORD_BITS;
					in_silence_q <= 1'b0;
					tick_count_q <= '0;
					sending_q    <= 1'b1;
				end
			end else if (sending_q) begin
				if (seg_end) begin
					tick_count_q <= '0;
					in_silence_q <= !in_silence_q;
					if (in_silence_q) begin
						bits_left_q <= bits_left_q - 6'd1;
						if (last_bit) begin
							sending_q <= 1'b0;
						end
					end
				end else begin
					tick_count_q <= tick_count_q + 11'd1;
				end
			end
		end
	end

	// The word register loads on a start while idle and shifts out one bit at the end of each silence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_word_q <= '0;
		end else if (accept) begin
			if (is_start && !sending_q) begin
				shift_word_q <= word;
			end else if (!is_start && sending_q && seg_end && in_silence_q) begin
				shift_word_q <= {shift_word_q[30:0], 1'b0};
			end
		end
	end

	`ODU_ASSERT_NOW(a_idle_no_bits, clk, arst_n, !sending_q, bits_left_q == 6'd0,
		"bit counter not cleared while idle")
	`ODU_ASSERT_NOW(a_busy_has_bits, clk, arst_n, sending_q, bits_left_q != 6'd0,
		"sending with no bits left")
	`ODU_ASSERT_NEXT(a_start_loads, clk, arst_n, accept && is_start && !sending_q,
		sending_q && bits_left_q == WORD_BITS && tick_count_q == 11'd0,
		"accepted start did not load the sequencer")
	`ODU_ASSERT_NEXT(a_done_idles, clk, arst_n, accept && res.frame_done, !sending_q,
		"frame end did not return to idle")

endmodule

`default_nettype wire

// File: rtl/core/odu_ccs_skid.sv
// Output register with a one-entry skid stage for the result channel.
// Depends on odu_ccs_pkg for the result struct.
`default_nettype none
`include "odu_channel_change_sender_core_defines.svh"

module odu_ccs_skid (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire odu_ccs_pkg::out_item_t push_data,
	output logic                   full,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output odu_ccs_pkg::out_item_t out_data
);
	import odu_ccs_pkg::*;

	logic      main_valid_q;
	logic      skid_valid_q;
	out_item_t main_q;
	out_item_t skid_q;
	logic      pop;

	assign pop       = main_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	// Valid flags: the skid entry drains first into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !main_valid_q) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload registers follow the same selection.
	always_ff @(posedge clk) begin
		if (pop || !main_valid_q) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	`ODU_ASSERT_NOW(a_skid_behind_main, clk, arst_n, skid_valid_q, main_valid_q,
		"skid entry held with empty output register")
	`ODU_ASSERT_NOW(a_no_push_when_full, clk, arst_n, skid_valid_q, !push,
		"transfer pushed into a full buffer")
	`ODU_ASSERT_NEXT(a_stall_fills_skid, clk, arst_n,
		main_valid_q && out_stall && push, skid_valid_q,
		"stalled transfer not caught by skid entry")

endmodule

`default_nettype wire

// File: rtl/core/odu_channel_change_sender_core.sv
// Top level of the channel change sender: configuration registers, bit
// sequencer with word assembly, and result buffer. Depends on odu_ccs_pkg.
//
// Channel   Signals                          Transfer when
// input     in_valid, in_stall, in_data      in_valid && !in_stall
// result    out_valid, out_stall, out_data   out_valid && !out_stall
// config    cfg_we, cfg_index, cfg_data      cfg_we
//
// Each item, tick or start, puts one result in the output register or skid entry.
// One item is taken per cycle while in_stall is low; the sequencer state and
// the word adder sit between the input transfer and the output register.
// in_stall rises only when the output register and its skid entry are both
// full, so a stalled result does not block the next item until then.
// Reset clears the sequencer, loads the register defaults and empties the buffer.
`default_nettype none

module odu_channel_change_sender_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire odu_ccs_pkg::in_item_t              in_data,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output odu_ccs_pkg::out_item_t                  out_data,
	input  wire logic                               cfg_we,
	input  wire logic [odu_ccs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [odu_ccs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import odu_ccs_pkg::*;

	cfg_t      cfg;
	out_item_t res;
	logic      accept;
	logic      full;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	odu_ccs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	odu_ccs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.accept (accept),
		.item   (in_data),
		.res    (res)
	);

	odu_ccs_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for odu_channel_change_sender_core: a scoreboard predicts each
// line-state result, and plain tasks drive starts, ticks and register writes.
// Depends on odu_ccs_pkg and the core RTL.
`default_nettype none

module tb;
	import odu_ccs_pkg::*;

	// Predicts the line state of every accepted request and checks each result transfer.
	class tone_frame_scoreboard;
		cfg_t        regs;
		logic [31:0] word_left;
		logic [5:0]  bits_to_go;
		logic        in_gap;
		logic [10:0] seg_ticks;
		logic        busy;
		out_item_t   awaited_lines[$];
		int          errors;

		function new();
			regs.short_us = RST_SHORT_US;
			regs.long_us = RST_LONG_US;
			regs.band_edge_mhz = RST_BAND_EDGE_MHZ;
			regs.low_lo_mhz = RST_LOW_LO_MHZ;
			regs.high_lo_mhz = RST_HIGH_LO_MHZ;
			regs.tune_offset_mhz = RST_TUNE_OFFSET_MHZ;
			word_left = '0;
			bits_to_go = '0;
			in_gap = 1'b0;
			seg_ticks = '0;
			busy = 1'b0;
			errors = 0;
		endfunction

		// Assembles the channel change word; all sums wrap at 32 bits.
		function logic [31:0] channel_word(logic [5:0] channel, logic [13:0] freq, logic pol);
			logic [7:0]  ch;
			logic [31:0] tune;
			logic [31:0] code;
			ch = {2'b00, channel} - 8'd1;
			code = pol ? 32'd3 : 32'd1;
			tune = 32'(freq);
			if (freq <= regs.band_edge_mhz) begin
				tune = tune - 32'(regs.low_lo_mhz);
				code = code - 32'd1;
			end else begin
				tune = tune - 32'(regs.high_lo_mhz);
			end
			tune = tune - 32'(regs.tune_offset_mhz);
			return {CMD_PREFIX, 24'd0} + (32'(ch) << 19) + (tune << 8) + code;
		endfunction

		// Advances the sequencer by one request and returns the line state it gives.
		function out_item_t line_result_for(in_item_t it);
			out_item_t   r;
			logic        one;
			logic [10:0] seg;
			r = '0;
			if (it.req_type == REQ_START) begin
				r.busy_res = 1'b1;
				if (busy) begin
					r.start_ignored = 1'b1;
				end else begin
					word_left = channel_word(it.channel, it.freq_mhz, it.polarity);
					r.command_word = word_left;
					bits_to_go = WORD_BITS;
					in_gap = 1'b0;
					seg_ticks = '0;
					busy = 1'b1;
				end
			end else if (busy) begin
				one = word_left[31];
				if (in_gap)
					seg = one ? regs.long_us : regs.short_us;
				else
					seg = one ? regs.short_us : regs.long_us;
				r.tone_on = ~in_gap;
				r.busy_res = 1'b1;
				// A length of zero behaves as one tick.
				if (int'(seg_ticks) + 1 >= int'(seg)) begin
					seg_ticks = '0;
					if (!in_gap) begin
						in_gap = 1'b1;
					end else begin
						in_gap = 1'b0;
						word_left = word_left << 1;
						bits_to_go = bits_to_go - 6'd1;
						if (bits_to_go == 6'd0) begin
							busy = 1'b0;
							r.frame_done = 1'b1;
						end
					end
				end else begin
					seg_ticks = seg_ticks + 11'd1;
				end
			end
			return r;
		endfunction

		function void note_request(in_item_t it);
			awaited_lines.push_back(line_result_for(it));
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (awaited_lines.size() == 0) begin
				$display("%0t: result with nothing expected, actual %h", $time, got);
				errors++;
				return;
			end
			want = awaited_lines.pop_front();
			compare("tone_on", 32'(want.tone_on), 32'(got.tone_on));
			compare("busy_res", 32'(want.busy_res), 32'(got.busy_res));
			compare("frame_done", 32'(want.frame_done), 32'(got.frame_done));
			compare("start_ignored", 32'(want.start_ignored), 32'(got.start_ignored));
			compare("command_word", want.command_word, got.command_word);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	tone_frame_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_pending = 1'b0;
	int hold_left = 0;

	odu_channel_change_sender_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// Result side stalls at random, or holds off for a long stretch when asked.
	always @(negedge clk) begin
		if (hold_pending) begin
			hold_pending = 1'b0;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Every result transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	// Offers one request after a random gap and returns at the falling edge after its transfer.
	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sb.note_request(it);
		@(negedge clk);
	endtask

	// Stops offering requests until every predicted result has arrived.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.awaited_lines.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	// Writes all six registers while nothing is in flight.
	task automatic apply_cfg(cfg_t c);
		drain_results();
		sb.regs = c;
		write_reg(CFG_SHORT_US, CFG_DATA_W'(c.short_us));
		write_reg(CFG_LONG_US, CFG_DATA_W'(c.long_us));
		write_reg(CFG_BAND_EDGE_MHZ, c.band_edge_mhz);
		write_reg(CFG_LOW_LO_MHZ, c.low_lo_mhz);
		write_reg(CFG_HIGH_LO_MHZ, c.high_lo_mhz);
		write_reg(CFG_TUNE_OFFSET_MHZ, CFG_DATA_W'(c.tune_offset_mhz));
		cfg_we <= 1'b0;
	endtask

	function automatic cfg_t rand_cfg(int max_len);
		cfg_t c;
		c.short_us = 11'($urandom_range(max_len, 1));
		c.long_us = 11'($urandom_range(max_len, 1));
		c.band_edge_mhz = 14'($urandom);
		c.low_lo_mhz = 14'($urandom);
		c.high_lo_mhz = 14'($urandom);
		c.tune_offset_mhz = 10'($urandom);
		return c;
	endfunction

	// Ticks carry random unused fields.
	function automatic in_item_t tick_item();
		in_item_t it;
		it = in_item_t'($urandom);
		it.req_type = REQ_TICK;
		return it;
	endfunction

	function automatic in_item_t start_item(logic [5:0] ch, logic [13:0] freq, logic pol);
		in_item_t it;
		it.req_type = REQ_START;
		it.channel = ch;
		it.freq_mhz = freq;
		it.polarity = pol;
		return it;
	endfunction

	// Mostly whole frames: a start when idle, then ticks, with a few starts while busy.
	function automatic in_item_t rand_request(int start_pct);
		in_item_t it;
		it = tick_item();
		if ($urandom_range(99) < 80)
			it.channel = 6'($urandom_range(32, 1));
		case ($urandom_range(5))
			0: it.freq_mhz = sb.regs.band_edge_mhz;
			1: it.freq_mhz = sb.regs.band_edge_mhz + 14'd1;
			2: it.freq_mhz = $urandom_range(1) ? 14'h3fff : 14'h0000;
			default: ;
		endcase
		if ($urandom_range(99) < (sb.busy ? 2 : start_pct))
			it.req_type = REQ_START;
		return it;
	endfunction

	task automatic finish_frame();
		while (sb.busy)
			send_item(tick_item());
	endtask

	task automatic run_random(int count, int start_pct, int hold_at, int pause_at);
		for (int n = 0; n < count; n++) begin
			if (n == hold_at)
				hold_pending = 1'b1;
			if (n == pause_at)
				drain_results();
			send_item(rand_request(start_pct));
		end
	endtask

	initial begin
		cfg_t c;
		sb = new();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 13;
		recv_stall_pct = 63;

		// Directed: idle tick, start at the band edge with reset registers, start while busy.
		send_item(tick_item());
		send_item(start_item(6'd1, RST_BAND_EDGE_MHZ, 1'b0));
		send_item(start_item(6'd32, 14'h3fff, 1'b1));
		repeat (3) send_item(tick_item());

		// Shorten the segments in mid frame; the running segment ends on the next tick.
		c = sb.regs;
		c.short_us = 11'd1;
		c.long_us = 11'd2;
		apply_cfg(c);
		finish_frame();

		// Zero short length, channel zero and the register extremes.
		c.short_us = 11'd0;
		c.long_us = 11'd1;
		c.band_edge_mhz = 14'd0;
		c.low_lo_mhz = 14'h3fff;
		c.high_lo_mhz = 14'd0;
		c.tune_offset_mhz = 10'h3ff;
		apply_cfg(c);
		send_item(start_item(6'd0, 14'd0, 1'b1));
		finish_frame();
		send_item(start_item(6'h3f, 14'h3fff, 1'b0));
		finish_frame();

		c.short_us = 11'd1;
		c.band_edge_mhz = 14'h3fff;
		c.low_lo_mhz = 14'd0;
		c.high_lo_mhz = 14'h3fff;
		c.tune_offset_mhz = 10'd0;
		apply_cfg(c);
		send_item(start_item(6'd32, 14'h3fff, 1'b1));
		finish_frame();
		send_item(tick_item());

		// Random frames, first with a slow receiver.
		apply_cfg(rand_cfg(4));
		run_random(250, 50, 100, 200);
		apply_cfg(rand_cfg(3));
		run_random(150, 30, -1, -1);

		// Then with a slow sender.
		send_idle_pct = 63;
		recv_stall_pct = 13;
		apply_cfg(rand_cfg(3));
		run_random(200, 50, -1, 120);
		apply_cfg(rand_cfg(4));
		run_random(200, 40, 60, -1);

		// No idling: a start with the longest segment length, cut short in mid segment
		// by new lengths, then short frames under back pressure.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		finish_frame();
		c = rand_cfg(1);
		c.short_us = 11'h7ff;
		apply_cfg(c);
		send_item(rand_request(100));
		repeat (24) send_item(tick_item());
		apply_cfg(rand_cfg(3));
		run_random(250, 50, 80, 200);
		apply_cfg(rand_cfg(2));
		run_random(150, 60, -1, -1);

		// Let every result arrive, then watch for stray transfers.
		in_valid <= 1'b0;
		for (int w = 0; w < 5000; w++) begin
			@(negedge clk);
			if (sb.awaited_lines.size() == 0)
				break;
		end
		repeat (8) @(posedge clk);
		if (sb.awaited_lines.size() != 0)
			$display("%0t: %0d results never arrived", $time, sb.awaited_lines.size());
		if (sb.errors == 0 && sb.awaited_lines.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#6000000;
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
